// ===== rtl/rc_receiver_drive_controller_assert.svh =====
// Assertion macros used by the checker file of the drive controller.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef RC_RECEIVER_DRIVE_CONTROLLER_ASSERT_SVH
`define RC_RECEIVER_DRIVE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RCDC_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rcdc: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RCDC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rcdc: next-cycle check failed");

// Condition that must hold at every clock edge seen while reset is applied.
`define RCDC_ASSERT_IN_RESET(label, cons) \
	label: assert property (@(posedge clk) !arst_n |-> (cons)) \
		else $error("rcdc: reset check failed");

`endif

// ===== rtl/rcdc_pkg.sv =====
package rcdc_pkg;

	// Sizes and defaults.
	localparam int PACKET_BYTES_DEF = 9;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int RX_COUNT_W = 4;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_SERVO_CENTER = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SERVO_RANGE = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ESC_NEUTRAL = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ESC_MIN = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_ESC_MAX = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_FAILSAFE = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_SPEED_WINDOW = 3'd6;

	// Command opcodes.
	localparam logic [1:0] OP_BYTE = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_PULSE = 2'd2;

	// Packet status codes.
	localparam logic [1:0] ST_NONE = 2'd0;
	localparam logic [1:0] ST_OK = 2'd1;
	localparam logic [1:0] ST_LENGTH = 2'd2;
	localparam logic [1:0] ST_CHECKSUM = 2'd3;

	// Floor division by 100 as a multiply by ceil(2^32 / 100) and a shift.
	// The excess of the constant is 4, so the result is exact below 2^30.
	localparam int RECIP_W = 26;
	localparam int RECIP_SHIFT = 32;
	localparam logic [RECIP_W-1:0] RECIP_100 = 26'd42949673;

	// What the back end does to the drive outputs for one word.
	typedef enum logic [1:0] {
		ACT_NONE = 2'd0,
		ACT_FAILSAFE = 2'd1,
		ACT_APPLY = 2'd2
	} act_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] byte_value;
		logic       last_byte;
	} cmd_t;

	typedef struct packed {
		logic [11:0] steer_us;
		logic [11:0] esc_us;
		logic        led1_on;
		logic        led2_on;
		logic        fan_on;
		logic        failsafe_active;
		logic [1:0]  packet_status;
		logic [15:0] window_pulses;
		logic [15:0] max_window_pulses;
	} res_t;

	typedef struct packed {
		logic [10:0] servo_center_us;
		logic [9:0]  steer_swing_us;
		logic [11:0] esc_neutral_us;
		logic [11:0] esc_min_us;
		logic [11:0] esc_max_us;
		logic [15:0] silence_limit;
		logic [15:0] window_len;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		servo_center_us: 11'd1500,
		steer_swing_us: 10'd400,
		esc_neutral_us: 12'd1500,
		esc_min_us: 12'd1000,
		esc_max_us: 12'd2000,
		silence_limit: 16'd500,
		window_len: 16'd100
	};

	// Drive outputs after reset: servo center and throttle neutral.
	localparam logic [11:0] DRIVE_STEER_RST = 12'd1500;
	localparam logic [11:0] DRIVE_ESC_RST = 12'd1500;

	// Word handed from the front end to the back end through the queue.
	typedef struct packed {
		act_t        act;
		logic [15:0] steering;
		logic [15:0] throttle;
		logic [2:0]  switches;
		logic        failsafe_active;
		logic [1:0]  packet_status;
		logic [15:0] window_pulses;
		logic [15:0] max_window_pulses;
	} work_t;

endpackage

// ===== rtl/rcdc_queue.sv =====
module rcdc_queue #(
	parameter int DEPTH = rcdc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rcdc_pkg::work_t push_word,
	output logic            full,
	input  logic            pop,
	output rcdc_pkg::work_t pop_word,
	output logic            avail
);
	import rcdc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	work_t            entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == FULL_CNT);
	assign avail = (count_q != '0);
	assign pop_word = entries_q[rd_ptr_q];

	// Storage for queued words.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_word;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10: begin
					count_q <= count_q + 1'b1;
				end
				2'b01: begin
					count_q <= count_q - 1'b1;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

endmodule

// ===== rtl/rcdc_front.sv =====
module rcdc_front #(
	parameter int PACKET_BYTES = rcdc_pkg::PACKET_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  rcdc_pkg::cmd_t  cmd_word,
	input  rcdc_pkg::cfg_t  cfg,
	output rcdc_pkg::work_t work
);
	import rcdc_pkg::*;

	localparam int PAYLOAD = PACKET_BYTES - 1;
	localparam int IDX_W = $clog2(PAYLOAD);
	localparam logic [RX_COUNT_W-1:0] PAYLOAD_CNT = RX_COUNT_W'(PAYLOAD);
	localparam logic [RX_COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [15:0] SAT16 = 16'hFFFF;

	logic [7:0]            rx_bytes_q [PAYLOAD];
	logic [RX_COUNT_W-1:0] rx_count_q, rx_count_d;
	logic [7:0]            rx_xor_q, rx_xor_d;
	logic [15:0]           pend_steer_q, pend_steer_d;
	logic [15:0]           pend_throttle_q, pend_throttle_d;
	logic [2:0]            pend_sw_q, pend_sw_d;
	logic                  pend_valid_q, pend_valid_d;
	logic [15:0]           silence_q, silence_d;
	logic [15:0]           window_q, window_d;
	logic [15:0]           pulse_q, pulse_d;
	logic [15:0]           last_win_q, last_win_d;
	logic [15:0]           max_win_q, max_win_d;
	logic [15:0]           silence_inc, window_inc, pulse_inc;
	logic                  store_en;
	logic [1:0]            status;
	act_t                  act;

	// Saturating increments of the three counters.
	assign silence_inc = (silence_q == SAT16) ? silence_q : silence_q + 16'd1;
	assign window_inc = (window_q == SAT16) ? window_q : window_q + 16'd1;
	assign pulse_inc = (pulse_q == SAT16) ? pulse_q : pulse_q + 16'd1;

	// Classify the incoming word and work out the next receiver and timer state.
	always_comb begin
		rx_count_d = rx_count_q;
		rx_xor_d = rx_xor_q;
		pend_steer_d = pend_steer_q;
		pend_throttle_d = pend_throttle_q;
		pend_sw_d = pend_sw_q;
		pend_valid_d = pend_valid_q;
		silence_d = silence_q;
		window_d = window_q;
		pulse_d = pulse_q;
		last_win_d = last_win_q;
		max_win_d = max_win_q;
		store_en = 1'b0;
		status = ST_NONE;
		act = ACT_NONE;
		unique case (cmd_word.opcode)
			OP_BYTE: begin
				if (cmd_word.last_byte) begin
					if (rx_count_q != PAYLOAD_CNT) begin
						status = ST_LENGTH;
					end else if (rx_xor_q != cmd_word.byte_value) begin
						status = ST_CHECKSUM;
					end else begin
						status = ST_OK;
						pend_steer_d = {rx_bytes_q[1], rx_bytes_q[0]};
						pend_throttle_d = {rx_bytes_q[3], rx_bytes_q[2]};
						pend_sw_d = {rx_bytes_q[7] != 8'd0, rx_bytes_q[6] != 8'd0,
							rx_bytes_q[5] != 8'd0};
						pend_valid_d = 1'b1;
						silence_d = '0;
					end
					rx_count_d = '0;
					rx_xor_d = '0;
				end else begin
					// Bytes past the payload are counted but neither stored nor summed.
					if (rx_count_q < PAYLOAD_CNT) begin
						store_en = 1'b1;
						rx_xor_d = rx_xor_q ^ cmd_word.byte_value;
					end
					if (rx_count_q != COUNT_MAX) begin
						rx_count_d = rx_count_q + 1'b1;
					end
				end
			end
			OP_TICK: begin
				window_d = window_inc;
				if (window_inc >= cfg.window_len) begin
					last_win_d = pulse_q;
					if (pulse_q > max_win_q) begin
						max_win_d = pulse_q;
					end
					pulse_d = '0;
					window_d = '0;
				end
				silence_d = silence_inc;
				if (silence_inc > cfg.silence_limit) begin
					act = ACT_FAILSAFE;
				end else if (pend_valid_q) begin
					act = ACT_APPLY;
					pend_valid_d = 1'b0;
				end
			end
			OP_PULSE: begin
				pulse_d = pulse_inc;
			end
			default: begin
				status = ST_NONE;
			end
		endcase
	end

	// Word for the back end.
	always_comb begin
		work.act = act;
		work.steering = pend_steer_q;
		work.throttle = pend_throttle_q;
		work.switches = pend_sw_q;
		work.failsafe_active = (silence_d > cfg.silence_limit);
		work.packet_status = status;
		work.window_pulses = last_win_d;
		work.max_window_pulses = max_win_d;
	end

	// Payload bytes of the packet being received.
	always_ff @(posedge clk) begin
		if (take && store_en) begin
			rx_bytes_q[rx_count_q[IDX_W-1:0]] <= cmd_word.byte_value;
		end
	end

	// Receiver, pending command and timer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_count_q <= '0;
			rx_xor_q <= '0;
			pend_steer_q <= '0;
			pend_throttle_q <= '0;
			pend_sw_q <= '0;
			pend_valid_q <= 1'b0;
			silence_q <= '0;
			window_q <= '0;
			pulse_q <= '0;
			last_win_q <= '0;
			max_win_q <= '0;
		end else if (take) begin
			rx_count_q <= rx_count_d;
			rx_xor_q <= rx_xor_d;
			pend_steer_q <= pend_steer_d;
			pend_throttle_q <= pend_throttle_d;
			pend_sw_q <= pend_sw_d;
			pend_valid_q <= pend_valid_d;
			silence_q <= silence_d;
			window_q <= window_d;
			pulse_q <= pulse_d;
			last_win_q <= last_win_d;
			max_win_q <= max_win_d;
		end
	end

endmodule

// ===== rtl/rcdc_back.sv =====
module rcdc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  rcdc_pkg::cfg_t  cfg,
	input  logic            avail,
	input  rcdc_pkg::work_t in_word,
	output logic            pop,
	input  logic            res_stall,
	output logic            res_valid,
	output rcdc_pkg::res_t  res_word
);
	import rcdc_pkg::*;

	localparam int PS_W = 26;
	localparam int PE_W = 28;
	localparam int QS_W = PS_W + RECIP_W - RECIP_SHIFT;
	localparam int QE_W = PE_W + RECIP_W - RECIP_SHIFT;
	localparam int SW = 24;
	localparam logic signed [SW-1:0] PULSE_MAX = 24'sd4095;

	logic adv;

	// Stage 1 signals.
	logic                 steer_neg, thr_neg, gain_neg;
	logic [15:0]          steer_mag, thr_mag;
	logic signed [12:0]   gain;
	logic [11:0]          gain_mag;
	logic                 valid_s1;
	work_t                work_s1;
	logic                 neg_s_s1, neg_e_s1;
	logic [PS_W-1:0]      prod_s_s1;
	logic [PE_W-1:0]      prod_e_s1;

	// Stage 2 signals.
	logic [PS_W+RECIP_W-1:0] wide_s;
	logic [PE_W+RECIP_W-1:0] wide_e;
	logic                    valid_s2;
	work_t                   work_s2;
	logic                    neg_s_s2, neg_e_s2;
	logic [QS_W-1:0]         quo_s_s2;
	logic [QE_W-1:0]         quo_e_s2;

	// Final stage signals.
	logic signed [SW-1:0] sq, eq, center, range, neutral, esc_lo, esc_hi;
	logic signed [SW-1:0] steer_val, esc_val;
	logic [11:0]          steer_cmd, esc_cmd;
	logic [11:0]          drive_steer_q, drive_steer_d;
	logic [11:0]          drive_esc_q, drive_esc_d;
	logic [2:0]           drive_sw_q, drive_sw_d;
	logic                 res_valid_q;
	res_t                 res_q;

	// The whole pipeline moves unless a finished word waits at the output.
	assign adv = !(res_valid_q && res_stall);
	assign pop = adv && avail;

	// Stage 1: magnitudes of the commands and gains, then one product each.
	always_comb begin
		steer_neg = in_word.steering[15];
		thr_neg = in_word.throttle[15];
		steer_mag = steer_neg ? 16'(-in_word.steering) : in_word.steering;
		thr_mag = thr_neg ? 16'(-in_word.throttle) : in_word.throttle;
		gain = signed'({1'b0, cfg.esc_max_us}) - signed'({1'b0, cfg.esc_neutral_us});
		gain_neg = gain[12];
		gain_mag = gain_neg ? 12'(-gain) : gain[11:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			work_s1 <= in_word;
			neg_s_s1 <= steer_neg;
			neg_e_s1 <= thr_neg ^ gain_neg;
			prod_s_s1 <= PS_W'(steer_mag) * PS_W'(cfg.steer_swing_us);
			prod_e_s1 <= PE_W'(thr_mag) * PE_W'(gain_mag);
		end
	end

	// Stage 2: truncating division by 100 through the reciprocal.
	assign wide_s = (PS_W + RECIP_W)'(prod_s_s1) * (PS_W + RECIP_W)'(RECIP_100);
	assign wide_e = (PE_W + RECIP_W)'(prod_e_s1) * (PE_W + RECIP_W)'(RECIP_100);

	always_ff @(posedge clk) begin
		if (adv) begin
			work_s2 <= work_s1;
			neg_s_s2 <= neg_s_s1;
			neg_e_s2 <= neg_e_s1;
			quo_s_s2 <= wide_s[PS_W+RECIP_W-1:RECIP_SHIFT];
			quo_e_s2 <= wide_e[PE_W+RECIP_W-1:RECIP_SHIFT];
		end
	end

	// Final stage: restore signs, offset, clamp and saturate.
	always_comb begin
		sq = signed'(SW'(quo_s_s2));
		if (neg_s_s2) begin
			sq = -sq;
		end
		eq = signed'(SW'(quo_e_s2));
		if (neg_e_s2) begin
			eq = -eq;
		end
		center = signed'(SW'(cfg.servo_center_us));
		range = signed'(SW'(cfg.steer_swing_us));
		neutral = signed'(SW'(cfg.esc_neutral_us));
		esc_lo = signed'(SW'(cfg.esc_min_us));
		esc_hi = signed'(SW'(cfg.esc_max_us));

		steer_val = center + sq;
		if (steer_val < center - range) begin
			steer_val = center - range;
		end
		if (steer_val > center + range) begin
			steer_val = center + range;
		end
		priority if (steer_val < 0) begin
			steer_cmd = '0;
		end else if (steer_val > PULSE_MAX) begin
			steer_cmd = '1;
		end else begin
			steer_cmd = steer_val[11:0];
		end

		esc_val = neutral + eq;
		priority if (esc_val < esc_lo) begin
			esc_val = esc_lo;
		end else if (esc_val > esc_hi) begin
			esc_val = esc_hi;
		end else begin
			esc_val = esc_val;
		end
		esc_cmd = esc_val[11:0];
	end

	// New drive state for the word leaving the pipeline.
	always_comb begin
		drive_steer_d = drive_steer_q;
		drive_esc_d = drive_esc_q;
		drive_sw_d = drive_sw_q;
		unique case (work_s2.act)
			ACT_APPLY: begin
				drive_steer_d = steer_cmd;
				drive_esc_d = esc_cmd;
				drive_sw_d = work_s2.switches;
			end
			ACT_FAILSAFE: begin
				drive_steer_d = 12'(cfg.servo_center_us);
				drive_esc_d = cfg.esc_neutral_us;
				drive_sw_d = '0;
			end
			ACT_NONE: begin
				drive_sw_d = drive_sw_q;
			end
			default: begin
				drive_sw_d = drive_sw_q;
			end
		endcase
	end

	// Stage valid bits and drive state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			res_valid_q <= 1'b0;
			drive_steer_q <= DRIVE_STEER_RST;
			drive_esc_q <= DRIVE_ESC_RST;
			drive_sw_q <= '0;
		end else if (adv) begin
			valid_s1 <= avail;
			valid_s2 <= valid_s1;
			res_valid_q <= valid_s2;
			if (valid_s2) begin
				drive_steer_q <= drive_steer_d;
				drive_esc_q <= drive_esc_d;
				drive_sw_q <= drive_sw_d;
			end
		end
	end

	// Output word register.
	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.steer_us <= drive_steer_d;
			res_q.esc_us <= drive_esc_d;
			res_q.led1_on <= drive_sw_d[0];
			res_q.led2_on <= drive_sw_d[1];
			res_q.fan_on <= drive_sw_d[2];
			res_q.failsafe_active <= work_s2.failsafe_active;
			res_q.packet_status <= work_s2.packet_status;
			res_q.window_pulses <= work_s2.window_pulses;
			res_q.max_window_pulses <= work_s2.max_window_pulses;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word = res_q;

endmodule

// ===== rtl/rc_receiver_drive_controller.sv =====
// Channel | Direction | Handshake               | Word
// cmd     | in        | cmd_valid / cmd_stall   | cmd_word: opcode, byte_value, last_byte
// res     | out       | res_valid / res_stall   | res_word: drive outputs, status, speed
// cfg     | in        | cfg_we (no wait)        | cfg_index, cfg_data
//
// One command word is taken per cycle while cmd_stall is low; each gives exactly one result word.
// The front end updates its state in the accepting cycle; the word then passes
// through the queue, the two multiply stages and the output register of the
// back end.
// Reset clears all counters and restores the register defaults; the drive
// outputs start at servo center and throttle neutral.
// A queue of QUEUE_DEPTH words sits between front and back; cmd_stall rises
// only when res_stall has held the back end long enough to fill it.
module rc_receiver_drive_controller #(
	parameter int PACKET_BYTES = rcdc_pkg::PACKET_BYTES_DEF,
	parameter int QUEUE_DEPTH = rcdc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	output logic                               cmd_stall,
	input  rcdc_pkg::cmd_t                     cmd_word,
	output logic                               res_valid,
	input  logic                               res_stall,
	output rcdc_pkg::res_t                     res_word,
	input  logic                               cfg_we,
	input  logic [rcdc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [rcdc_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import rcdc_pkg::*;

	cfg_t  cfg_q;
	logic  take;
	logic  queue_full, queue_avail, queue_pop;
	work_t front_word, queue_word;

	assign cmd_stall = queue_full;
	assign take = cmd_valid && !queue_full;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SERVO_CENTER: begin
					cfg_q.servo_center_us <= cfg_data[10:0];
				end
				REG_SERVO_RANGE: begin
					cfg_q.steer_swing_us <= cfg_data[9:0];
				end
				REG_ESC_NEUTRAL: begin
					cfg_q.esc_neutral_us <= cfg_data[11:0];
				end
				REG_ESC_MIN: begin
					cfg_q.esc_min_us <= cfg_data[11:0];
				end
				REG_ESC_MAX: begin
					cfg_q.esc_max_us <= cfg_data[11:0];
				end
				REG_FAILSAFE: begin
					cfg_q.silence_limit <= cfg_data;
				end
				REG_SPEED_WINDOW: begin
					cfg_q.window_len <= cfg_data;
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// Front end: packet receiver, timers and failsafe decision.
	rcdc_front #(
		.PACKET_BYTES(PACKET_BYTES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.cmd_word(cmd_word),
		.cfg(cfg_q),
		.work(front_word)
	);

	// Queue between front and back end.
	rcdc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(take),
		.push_word(front_word),
		.full(queue_full),
		.pop(queue_pop),
		.pop_word(queue_word),
		.avail(queue_avail)
	);

	// Back end: command scaling and drive outputs.
	rcdc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.avail(queue_avail),
		.in_word(queue_word),
		.pop(queue_pop),
		.res_stall(res_stall),
		.res_valid(res_valid),
		.res_word(res_word)
	);

endmodule

// ===== rtl/rcdc_checker.sv =====
`include "rc_receiver_drive_controller_assert.svh"

module rcdc_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           res_valid,
	input logic           res_stall,
	input rcdc_pkg::res_t res_word
);

	logic [15:0] max_seen_q;

	// Largest window count delivered so far.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_seen_q <= '0;
		end else if (res_valid && !res_stall) begin
			max_seen_q <= res_word.max_window_pulses;
		end
	end

	// A stalled result word stays put.
	`RCDC_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_word))

	// The maximum window count is never below the last closed window.
	`RCDC_ASSERT_IMPLY(a_max_covers_last, res_valid,
		res_word.max_window_pulses >= res_word.window_pulses)

	// The maximum window count never falls from one word to the next.
	`RCDC_ASSERT_IMPLY(a_max_monotonic, res_valid, res_word.max_window_pulses >= max_seen_q)

	// No result word is offered while reset is applied.
	`RCDC_ASSERT_IN_RESET(a_reset_quiet, !res_valid)

endmodule

bind rc_receiver_drive_controller rcdc_checker u_rcdc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.res_word(res_word)
);

// ===== tb/rc_receiver_drive_controller_check.sv =====
`timescale 1ns / 1ps

module rc_receiver_drive_controller_check import rcdc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	input  logic                   cmd_stall,
	input  cmd_t                   cmd_word,
	input  logic                   res_valid,
	input  logic                   res_stall,
	input  res_t                   res_word,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int unsigned            outstanding,
	output int unsigned            mismatches
);

	localparam int PAYLOAD_LEN = PACKET_BYTES_DEF - 1;

	// Register copy and the controller state as the predictor sees it.
	cfg_t        regs;
	logic [7:0]  rx_payload [0:PAYLOAD_LEN-1];
	logic [3:0]  rx_count;
	logic [7:0]  rx_sum;
	logic [15:0] pend_steer;
	logic [15:0] pend_throttle;
	logic [2:0]  pend_sw;
	logic        pend_valid;
	logic [15:0] silence;
	logic [15:0] win_ticks;
	logic [15:0] pulses;
	logic [15:0] last_win;
	logic [15:0] max_win;
	logic [11:0] out_steer;
	logic [11:0] out_esc;
	logic [2:0]  out_sw;

	res_t expected_drive_words [$];
	res_t want;

	function automatic logic [11:0] clip12(longint v);
		if (v < 0)
			return 12'd0;
		if (v > 4095)
			return 12'hFFF;
		return v[11:0];
	endfunction

	// Advances the state by one command word and returns the drive word it should produce.
	function automatic res_t predict_drive_word(cmd_t w);
		res_t       r;
		logic [1:0] status;
		longint     c, rng, st, s, n, th, mn, mx, e;
		status = ST_NONE;
		case (w.opcode)
		OP_BYTE: begin
			if (w.last_byte) begin
				if (rx_count != PAYLOAD_LEN) begin
					status = ST_LENGTH;
				end else if (rx_sum != w.byte_value) begin
					status = ST_CHECKSUM;
				end else begin
					pend_steer = {rx_payload[1], rx_payload[0]};
					pend_throttle = {rx_payload[3], rx_payload[2]};
					pend_sw = {rx_payload[7] != 8'd0, rx_payload[6] != 8'd0,
						rx_payload[5] != 8'd0};
					pend_valid = 1'b1;
					silence = '0;
					status = ST_OK;
				end
				rx_count = '0;
				rx_sum = '0;
			end else begin
				// Bytes past the payload are counted but neither stored nor summed.
				if (rx_count < PAYLOAD_LEN) begin
					rx_payload[rx_count[2:0]] = w.byte_value;
					rx_sum ^= w.byte_value;
				end
				if (rx_count != 4'hF)
					rx_count++;
			end
		end
		OP_TICK: begin
			// Speed window first, then silence, then the drive outputs.
			if (win_ticks != 16'hFFFF)
				win_ticks++;
			if (win_ticks >= regs.window_len) begin
				last_win = pulses;
				if (pulses > max_win)
					max_win = pulses;
				pulses = '0;
				win_ticks = '0;
			end
			if (silence != 16'hFFFF)
				silence++;
			if (silence > regs.silence_limit) begin
				out_steer = 12'(regs.servo_center_us);
				out_esc = regs.esc_neutral_us;
				out_sw = '0;
			end else if (pend_valid) begin
				c = longint'(regs.servo_center_us);
				rng = longint'(regs.steer_swing_us);
				st = longint'($signed(pend_steer));
				s = c + st * rng / 100;
				if (s < c - rng)
					s = c - rng;
				if (s > c + rng)
					s = c + rng;
				out_steer = clip12(s);
				n = longint'(regs.esc_neutral_us);
				mn = longint'(regs.esc_min_us);
				mx = longint'(regs.esc_max_us);
				th = longint'($signed(pend_throttle));
				e = n + th * (mx - n) / 100;
				if (e < mn)
					e = mn;
				else if (e > mx)
					e = mx;
				out_esc = clip12(e);
				out_sw = pend_sw;
				pend_valid = 1'b0;
			end
		end
		OP_PULSE: begin
			if (pulses != 16'hFFFF)
				pulses++;
		end
		default: begin
		end
		endcase
		r.steer_us = out_steer;
		r.esc_us = out_esc;
		r.led1_on = out_sw[0];
		r.led2_on = out_sw[1];
		r.fan_on = out_sw[2];
		r.failsafe_active = silence > regs.silence_limit;
		r.packet_status = status;
		r.window_pulses = last_win;
		r.max_window_pulses = max_win;
		return r;
	endfunction

	task automatic check_field(string field, longint unsigned exp_val, longint unsigned act_val);
		if (exp_val != act_val) begin
			$display("%0t: %s expected %0d, got %0d", $time, field, exp_val, act_val);
			mismatches++;
		end
	endtask

	// Watch both channels and the register port on every edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = CFG_RESET;
			rx_count = '0;
			rx_sum = '0;
			pend_steer = '0;
			pend_throttle = '0;
			pend_sw = '0;
			pend_valid = 1'b0;
			silence = '0;
			win_ticks = '0;
			pulses = '0;
			last_win = '0;
			max_win = '0;
			out_steer = 12'(CFG_RESET.servo_center_us);
			out_esc = CFG_RESET.esc_neutral_us;
			out_sw = '0;
			expected_drive_words.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			// Compare before predicting, so a stray result never meets this edge's word.
			if (res_valid && !res_stall) begin
				if (expected_drive_words.size() == 0) begin
					$display("%0t: result word expected none, got %h", $time, res_word);
					mismatches++;
				end else begin
					want = expected_drive_words.pop_front();
					check_field("steer_us", want.steer_us, res_word.steer_us);
					check_field("esc_us", want.esc_us, res_word.esc_us);
					check_field("led1_on", want.led1_on, res_word.led1_on);
					check_field("led2_on", want.led2_on, res_word.led2_on);
					check_field("fan_on", want.fan_on, res_word.fan_on);
					check_field("failsafe_active", want.failsafe_active,
						res_word.failsafe_active);
					check_field("packet_status", want.packet_status, res_word.packet_status);
					check_field("window_pulses", want.window_pulses, res_word.window_pulses);
					check_field("max_window_pulses", want.max_window_pulses,
						res_word.max_window_pulses);
				end
			end
			if (cmd_valid && !cmd_stall)
				expected_drive_words.push_back(predict_drive_word(cmd_word));
			if (cfg_we) begin
				case (cfg_index)
				REG_SERVO_CENTER: regs.servo_center_us = cfg_data[10:0];
				REG_SERVO_RANGE: regs.steer_swing_us = cfg_data[9:0];
				REG_ESC_NEUTRAL: regs.esc_neutral_us = cfg_data[11:0];
				REG_ESC_MIN: regs.esc_min_us = cfg_data[11:0];
				REG_ESC_MAX: regs.esc_max_us = cfg_data[11:0];
				REG_FAILSAFE: regs.silence_limit = cfg_data;
				REG_SPEED_WINDOW: regs.window_len = cfg_data;
				default: begin
				end
				endcase
			end
			outstanding <= expected_drive_words.size();
		end
	end

endmodule

// ===== tb/tb_rc_receiver_drive_controller.sv =====
`timescale 1ns / 1ps

module tb_rc_receiver_drive_controller;
	import rcdc_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   cmd_valid = 1'b0;
	logic                   cmd_stall;
	cmd_t                   cmd_word = '0;
	logic                   res_valid;
	logic                   res_stall = 1'b0;
	res_t                   res_word;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	int unsigned            outstanding;
	int unsigned            mismatches;

	int unsigned sender_idle_pct = 0;
	int unsigned receiver_stall_pct = 0;
	int unsigned words_sent = 0;
	cfg_t        setting;

	rc_receiver_drive_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_word(cmd_word),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_word(res_word),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	rc_receiver_drive_controller_check drive_check (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_word(cmd_word),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_word(res_word),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.outstanding(outstanding),
		.mismatches(mismatches)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// The result side stalls at random at the current rate.
	always @(posedge clk) begin
		res_stall <= ($urandom_range(99) < receiver_stall_pct);
	end

	// Offers one command word after a random gap and holds it until it is taken.
	task automatic send_word(input logic [1:0] op, input logic [7:0] value, input logic last);
		while ($urandom_range(99) < sender_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_word <= '{opcode: op, byte_value: value, last_byte: last};
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		if (op != OP_UNUSED)
			words_sent++;
	endtask

	// Steering or throttle command: half the time between -150 and 150, otherwise any value or an extreme one.
	function automatic logic [15:0] pick_command();
		case ($urandom_range(3))
		0, 1: return 16'(int'($urandom_range(300)) - 150);
		2: return 16'($urandom);
		default: begin
			case ($urandom_range(3))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return 16'hFFFF;
			endcase
		end
		endcase
	endfunction

	// Sends a packet of the given length; only a nine byte one carries a checksum.
	task automatic send_packet(input int unsigned length, input logic [15:0] steer_cmd,
		input logic [15:0] throttle_cmd, input bit corrupt_sum);
		logic [7:0] payload [0:7];
		logic [7:0] sum;
		payload[0] = steer_cmd[7:0];
		payload[1] = steer_cmd[15:8];
		payload[2] = throttle_cmd[7:0];
		payload[3] = throttle_cmd[15:8];
		payload[4] = 8'($urandom);
		for (int i = 5; i < 8; i++)
			payload[i] = $urandom_range(1) ? 8'($urandom_range(1, 255)) : 8'd0;
		sum = '0;
		for (int i = 0; i < 8; i++)
			sum ^= payload[i];
		for (int i = 0; i + 1 < length; i++)
			send_word(OP_BYTE, (i < 8) ? payload[i] : 8'($urandom), 1'b0);
		if (length == PACKET_BYTES_DEF)
			send_word(OP_BYTE, corrupt_sum ? sum ^ 8'($urandom_range(1, 255)) : sum, 1'b1);
		else
			send_word(OP_BYTE, 8'($urandom), 1'b1);
	endtask

	// Holds the command side quiet until every expected word has come back.
	task automatic wait_idle();
		cmd_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (4)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic program_regs(input cfg_t s);
		write_reg(REG_SERVO_CENTER, 16'(s.servo_center_us));
		write_reg(REG_SERVO_RANGE, 16'(s.steer_swing_us));
		write_reg(REG_ESC_NEUTRAL, 16'(s.esc_neutral_us));
		write_reg(REG_ESC_MIN, 16'(s.esc_min_us));
		write_reg(REG_ESC_MAX, 16'(s.esc_max_us));
		write_reg(REG_FAILSAFE, s.silence_limit);
		write_reg(REG_SPEED_WINDOW, s.window_len);
		cfg_we <= 1'b0;
	endtask

	// Well-formed packets between ticks and pulses, with broken packets and noise.
	task automatic run_random(input int unsigned count);
		int unsigned target;
		int unsigned pick;
		int unsigned length;
		target = words_sent + count;
		while (words_sent < target) begin
			pick = $urandom_range(99);
			if (pick < 35) begin
				send_packet(PACKET_BYTES_DEF, pick_command(), pick_command(), 1'b0);
			end else if (pick < 42) begin
				length = $urandom_range(1, 17);
				if (length >= PACKET_BYTES_DEF)
					length++;
				if ($urandom_range(1))
					send_packet(PACKET_BYTES_DEF, pick_command(), pick_command(), 1'b1);
				else
					send_packet(length, pick_command(), pick_command(), 1'b0);
			end else if (pick < 70) begin
				send_word(OP_TICK, 8'($urandom), 1'($urandom));
			end else if (pick < 90) begin
				send_word(OP_PULSE, 8'($urandom), 1'($urandom));
			end else if (pick < 95) begin
				send_word(OP_UNUSED, 8'($urandom), 1'($urandom));
			end else begin
				send_word(OP_BYTE, 8'($urandom), 1'b0);
			end
		end
	endtask

	initial begin
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		sender_idle_pct = 18;
		receiver_stall_pct = 55;

		// Directed words under the reset register values.
		send_word(OP_UNUSED, 8'hFF, 1'b1);
		send_word(OP_PULSE, 8'h00, 1'b0);
		send_word(OP_TICK, 8'hFF, 1'b1);
		send_packet(PACKET_BYTES_DEF, 16'h7FFF, 16'h8000, 1'b0);
		send_word(OP_TICK, 8'h00, 1'b0);
		send_word(OP_BYTE, 8'h5A, 1'b1);
		send_packet(PACKET_BYTES_DEF, 16'hFF9C, 16'd100, 1'b1);

		// Random phases, each under its own register setting and one of three idling patterns.
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
			0: setting = '{servo_center_us: 11'd1500, steer_swing_us: 10'd400,
				esc_neutral_us: 12'd1500, esc_min_us: 12'd1000, esc_max_us: 12'd2000,
				silence_limit: 16'd4, window_len: 16'd3};
			1: setting = '{servo_center_us: 11'd1000, steer_swing_us: 10'd0,
				esc_neutral_us: 12'd500, esc_min_us: 12'd500, esc_max_us: 12'd500,
				silence_limit: 16'd1, window_len: 16'd1};
			2: setting = '{servo_center_us: 11'd2000, steer_swing_us: 10'd1000,
				esc_neutral_us: 12'd2500, esc_min_us: 12'd2500, esc_max_us: 12'd2500,
				silence_limit: 16'd65534, window_len: 16'd65535};
			3: setting = '{servo_center_us: 11'd1800, steer_swing_us: 10'd700,
				esc_neutral_us: 12'd1200, esc_min_us: 12'd2200, esc_max_us: 12'd800,
				silence_limit: 16'd6, window_len: 16'd0};
			4: setting = '{servo_center_us: 11'($urandom_range(1000, 2000)),
				steer_swing_us: 10'($urandom_range(1000)),
				esc_neutral_us: 12'($urandom_range(500, 2500)),
				esc_min_us: 12'($urandom_range(500, 2500)),
				esc_max_us: 12'($urandom_range(500, 2500)),
				silence_limit: 16'($urandom_range(1, 12)),
				window_len: 16'($urandom_range(8))};
			default: setting = '{servo_center_us: 11'($urandom_range(1000, 2000)),
				steer_swing_us: 10'($urandom_range(1000)),
				esc_neutral_us: 12'($urandom_range(500, 2500)),
				esc_min_us: 12'($urandom_range(500, 2500)),
				esc_max_us: 12'($urandom_range(500, 2500)),
				silence_limit: 16'($urandom_range(1, 65534)),
				window_len: 16'($urandom_range(1, 65535))};
			endcase
			wait_idle();
			program_regs(setting);
			if (phase < 2) begin
				sender_idle_pct = 18;
				receiver_stall_pct = 55;
			end else if (phase < 4) begin
				sender_idle_pct = 55;
				receiver_stall_pct = 18;
			end else begin
				sender_idle_pct = 0;
				receiver_stall_pct = 0;
			end
			run_random(100);
		end

		// Short quiet stretch: failsafe engages, then a fresh packet takes over again.
		wait_idle();
		program_regs('{servo_center_us: 11'd1500, steer_swing_us: 10'd400,
			esc_neutral_us: 12'd1500, esc_min_us: 12'd1000, esc_max_us: 12'd2000,
			silence_limit: 16'd3, window_len: 16'd2});
		repeat (4)
			send_word(OP_PULSE, 8'($urandom), 1'($urandom));
		repeat (6)
			send_word(OP_TICK, 8'($urandom), 1'($urandom));
		send_packet(PACKET_BYTES_DEF, pick_command(), pick_command(), 1'b0);
		send_word(OP_TICK, 8'h00, 1'b0);
		send_word(OP_TICK, 8'hFF, 1'b1);

		wait_idle();
		repeat (16)
			@(posedge clk);
		if (mismatches == 0)
			$display("[rc_receiver_drive_controller] OK");
		else
			$display("[rc_receiver_drive_controller] ERROR");
		$finish;
	end

	// Abort a run that hangs.
	initial begin
		#12_000_000;
		$display("[rc_receiver_drive_controller] ERROR");
		$finish;
	end

endmodule
